@@ hdl/bpfa_pkg.sv @@
// ============================================================================
// bpfa_pkg
// Shared types, constants and helper functions of the bitmap page allocator.
// ============================================================================
package bpfa_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned WORD_LSB = 5;
    localparam int unsigned CNT_W    = 13;

    localparam logic [CNT_W-1:0] CNT_MAX = 13'h1FFF;

    localparam logic [2:0] OP_REQUEST   = 3'd0;
    localparam logic [2:0] OP_FREE      = 3'd1;
    localparam logic [2:0] OP_LOCK      = 3'd2;
    localparam logic [2:0] OP_RESERVE   = 3'd3;
    localparam logic [2:0] OP_UNRESERVE = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] target_page;
    } bpfa_req_t;

    typedef struct packed {
        logic        ok;
        logic [11:0] granted_page;
        logic [12:0] free_pages;
        logic [12:0] used_pages;
        logic [12:0] reserved_pages;
    } bpfa_rsp_t;

    typedef struct packed {
        logic clear_en;
        logic take;
        logic read_hint;
        logic read_target;
        logic step_next;
        logic grant;
        logic fail_req;
        logic apply;
        logic reject;
        logic load_out;
    } bpfa_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_request;
        logic op_known;
        logic target_bad;
        logic hint_at_end;
        logic bit_match;
        logic found;
        logic cand_ok;
        logic next_at_end;
    } bpfa_stat_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 13'd1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
        return (v == '0) ? v : v - 13'd1;
    endfunction

endpackage

@@ hdl/bpfa_ctrl.sv @@
// ============================================================================
// bpfa_ctrl
// Sequencer of the page allocator: clears the bitmap after reset, takes one
// request at a time, drives the bitmap scan and hands the result out.
// ============================================================================
module bpfa_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  bpfa_pkg::bpfa_stat_t   stat,
    output bpfa_pkg::bpfa_cmd_t    cmd
);
    import bpfa_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!stat.op_known)
                begin
                    cmd.reject = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (stat.is_request)
                begin
                    if (stat.hint_at_end)
                    begin
                        cmd.reject = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.read_hint = 1'b1;
                        state_next    = ST_CHECK;
                    end
                end
                else if (stat.target_bad)
                begin
                    cmd.reject = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.read_target = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.is_request)
                begin
                    if (stat.found)
                    begin
                        cmd.grant    = stat.cand_ok;
                        cmd.fail_req = !stat.cand_ok;
                        state_next   = ST_FINISH;
                    end
                    else if (stat.next_at_end)
                    begin
                        cmd.fail_req = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        cmd.step_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.reject = stat.bit_match;
                    cmd.apply  = !stat.bit_match;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/bpfa_datapath.sv @@
// ============================================================================
// bpfa_datapath
// Bitmap memory, search hint, page counters and result registers of the
// page allocator, stepped by the sequencer's commands.
// ============================================================================
module bpfa_datapath #(
    parameter int unsigned NUM_PAGES = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bpfa_pkg::bpfa_req_t    in_data,
    output bpfa_pkg::bpfa_rsp_t    out_data,
    input  logic                   cfg_we,
    input  logic [12:0]            cfg_wdata,
    input  bpfa_pkg::bpfa_cmd_t    cmd,
    output bpfa_pkg::bpfa_stat_t   stat
);
    import bpfa_pkg::*;

    localparam int unsigned DEPTH = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [12:0] NP_CAP  = (NUM_PAGES > 8191) ? 13'd8191 : 13'(NUM_PAGES);
    localparam logic [12:0] ACT_RST = (NUM_PAGES < 4096) ? 13'(NUM_PAGES) : 13'd4096;

    logic [WORD_W-1:0] mem [DEPTH];

    logic [2:0]        op_reg;
    logic [11:0]       page_reg;
    logic [12:0]       eff_reg;
    logic [12:0]       hint_reg;
    logic [12:0]       hint_next;
    logic [12:0]       used_reg;
    logic [12:0]       used_next;
    logic [12:0]       rsv_reg;
    logic [12:0]       rsv_next;
    logic [AW-1:0]     clr_addr_reg;
    logic [AW-1:0]     word_addr_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              res_ok_reg;
    logic [11:0]       res_page_reg;
    bpfa_rsp_t         out_data_reg;

    logic [31:0]       hint_word32;
    logic [31:0]       target_word32;
    logic [31:0]       next_word32;
    logic [13:0]       next_base;
    logic [WORD_W-1:0] low_mask;
    logic [WORD_W-1:0] masked;
    logic [4:0]        zero_pos;
    logic [12:0]       cand;
    logic              want;
    logic [WORD_W-1:0] bit_sel;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [13:0]       taken;
    logic [12:0]       free_cnt;

    assign hint_word32   = 32'(hint_reg) >> WORD_LSB;
    assign target_word32 = 32'(page_reg) >> WORD_LSB;
    assign next_base     = 14'({hint_reg[12:WORD_LSB], 5'b0}) + 14'(WORD_W);
    assign next_word32   = 32'(next_base) >> WORD_LSB;

    assign low_mask = (WORD_W'(1) << hint_reg[WORD_LSB-1:0]) - WORD_W'(1);
    assign masked   = rd_data_reg | low_mask;
    assign cand     = {hint_reg[12:WORD_LSB], zero_pos};
    assign want     = (op_reg == OP_LOCK) || (op_reg == OP_RESERVE);
    assign bit_sel  = WORD_W'(1) << page_reg[WORD_LSB-1:0];

    always_comb
    begin
        zero_pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!masked[i])
            begin
                zero_pos = 5'(i);
            end
        end
    end

    assign stat.clear_done  = (clr_addr_reg == LAST_ADDR);
    assign stat.is_request  = (op_reg == OP_REQUEST);
    assign stat.op_known    = (op_reg == OP_REQUEST) || (op_reg == OP_FREE)
                              || (op_reg == OP_LOCK) || (op_reg == OP_RESERVE)
                              || (op_reg == OP_UNRESERVE);
    assign stat.target_bad  = ({1'b0, page_reg} >= eff_reg);
    assign stat.hint_at_end = (hint_reg >= eff_reg);
    assign stat.bit_match   = (rd_data_reg[page_reg[WORD_LSB-1:0]] == want);
    assign stat.found       = !(&masked);
    assign stat.cand_ok     = (cand < eff_reg);
    assign stat.next_at_end = (next_base >= {1'b0, eff_reg});

    always_comb
    begin
        rd_en   = cmd.read_hint || cmd.read_target || cmd.step_next;
        rd_addr = hint_word32[AW-1:0];
        if (cmd.read_target)
        begin
            rd_addr = target_word32[AW-1:0];
        end
        else if (cmd.step_next)
        begin
            rd_addr = next_word32[AW-1:0];
        end
        wr_en   = cmd.clear_en || cmd.grant || cmd.apply;
        wr_addr = cmd.clear_en ? clr_addr_reg : word_addr_reg;
        wr_data = '0;
        if (cmd.grant)
        begin
            wr_data = rd_data_reg | (WORD_W'(1) << zero_pos);
        end
        else if (cmd.apply)
        begin
            wr_data = want ? (rd_data_reg | bit_sel) : (rd_data_reg & ~bit_sel);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg   <= mem[rd_addr];
            word_addr_reg <= rd_addr;
        end
    end

    always_comb
    begin
        hint_next = hint_reg;
        used_next = used_reg;
        rsv_next  = rsv_reg;
        if (cmd.step_next)
        begin
            hint_next = next_base[12:0];
        end
        else if (cmd.fail_req)
        begin
            hint_next = eff_reg;
        end
        else if (cmd.grant)
        begin
            hint_next = cand;
            used_next = sat_inc(used_reg);
        end
        else if (cmd.apply)
        begin
            case (op_reg)
                OP_FREE:
                begin
                    used_next = sat_dec(used_reg);
                    if (hint_reg > {1'b0, page_reg})
                    begin
                        hint_next = {1'b0, page_reg};
                    end
                end
                OP_LOCK:
                begin
                    used_next = sat_inc(used_reg);
                end
                OP_RESERVE:
                begin
                    rsv_next = sat_inc(rsv_reg);
                end
                OP_UNRESERVE:
                begin
                    rsv_next = sat_dec(rsv_reg);
                    if (hint_reg > {1'b0, page_reg})
                    begin
                        hint_next = {1'b0, page_reg};
                    end
                end
                default:
                begin
                    hint_next = hint_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_reg      <= ACT_RST;
            hint_reg     <= '0;
            used_reg     <= '0;
            rsv_reg      <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                eff_reg <= (cfg_wdata > NP_CAP) ? NP_CAP : cfg_wdata;
            end
            hint_reg <= hint_next;
            used_reg <= used_next;
            rsv_reg  <= rsv_next;
            if (cmd.clear_en && !stat.clear_done)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    assign taken    = {1'b0, used_reg} + {1'b0, rsv_reg};
    assign free_cnt = ({1'b0, eff_reg} > taken) ? 13'({1'b0, eff_reg} - taken) : 13'd0;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg   <= in_data.opcode;
            page_reg <= in_data.target_page;
        end
        if (cmd.grant)
        begin
            res_ok_reg   <= 1'b1;
            res_page_reg <= cand[11:0];
        end
        else if (cmd.apply)
        begin
            res_ok_reg   <= 1'b1;
            res_page_reg <= '0;
        end
        else if (cmd.reject || cmd.fail_req)
        begin
            res_ok_reg   <= 1'b0;
            res_page_reg <= '0;
        end
        if (cmd.load_out)
        begin
            out_data_reg.ok             <= res_ok_reg;
            out_data_reg.granted_page   <= res_page_reg;
            out_data_reg.free_pages     <= free_cnt;
            out_data_reg.used_pages     <= used_reg;
            out_data_reg.reserved_pages <= rsv_reg;
        end
    end

    assign out_data = out_data_reg;

`ifndef SYNTHESIS
    a_grant_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> (stat.found && stat.cand_ok))
        else $error("Page granted without a free bit in range.");

    a_apply_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> (!stat.target_bad && !stat.bit_match))
        else $error("Page bit changed out of range or without effect.");

    a_grant_hint: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |=> (hint_reg < eff_reg))
        else $error("Search hint left beyond the active pages after a grant.");

    a_fail_hint: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fail_req && !cfg_we) |=> (hint_reg == eff_reg))
        else $error("Search hint not parked at the active count after a failed request.");
`endif

endmodule

@@ hdl/bitmap_page_frame_allocator.sv @@
// ============================================================================
// bitmap_page_frame_allocator
// First-fit page frame allocator over a bitmap of page-in-use bits.
// ============================================================================
// Requests enter on in_valid/in_stall with in_data (opcode, target_page); each
// request gives exactly one response on out_valid/out_stall with out_data.
// The user must write the active page count through cfg_we/cfg_wdata only
// while idle; the block does not enforce this. The bitmap is held in 32-bit
// words of one memory; a page request scans it one word per cycle from the
// search hint until it finds a free page or passes the last active page.
// Free, lock, reserve and unreserve read the target page's word and write it
// back if the page's bit changes. One request is in work at a time; a new one
// is taken as soon as the previous response sits in the output register.
// After reset the block clears the bitmap's ceil(NUM_PAGES / 32) words (128 at
// the default), one word per cycle, with in_stall high.
// When the receiver stalls, the response holds in the output register and a
// finished request waits until that register frees up.
// ============================================================================
module bitmap_page_frame_allocator #(
    parameter int unsigned NUM_PAGES = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  bpfa_pkg::bpfa_req_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output bpfa_pkg::bpfa_rsp_t   out_data,
    input  logic                  cfg_we,
    input  logic [12:0]           cfg_wdata
);
    import bpfa_pkg::*;

    bpfa_cmd_t  cmd;
    bpfa_stat_t stat;

    bpfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpfa_datapath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ sim/bpfa_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bpfa_scoreboard_pkg
// Predicts the response to every accepted allocator request from a private
// copy of the page bitmap, search hint and page counters, and checks each
// response against the oldest prediction.
// ============================================================================
package bpfa_scoreboard_pkg;

    import bpfa_pkg::*;

    localparam int unsigned PAGE_SLOTS   = 4096;
    localparam int unsigned REPORT_LIMIT = 10;

    class page_alloc_scoreboard;

        bit          page_taken [PAGE_SLOTS];
        int unsigned search_pos;
        int unsigned used_cnt;
        int unsigned resv_cnt;
        logic [12:0] active_cfg;
        bpfa_rsp_t   expected_q [$];
        int unsigned mismatches;

        function new();
            foreach (page_taken[i])
            begin
                page_taken[i] = 1'b0;
            end
            search_pos = 0;
            used_cnt   = 0;
            resv_cnt   = 0;
            active_cfg = 13'd4096;
            mismatches = 0;
        endfunction

        function void set_active(input logic [12:0] value);
            active_cfg = value;
        endfunction

        function int unsigned span();
            return (active_cfg > PAGE_SLOTS) ? PAGE_SLOTS : int'(active_cfg);
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        // Every page below the search position is in use, so a page taken
        // from there is sure to be set.
        function logic [11:0] pick_taken(input logic [11:0] fallback);
            int unsigned top;
            int unsigned p;
            top = (search_pos < span()) ? search_pos : span();
            if (top > 0)
            begin
                return 12'($urandom_range(0, top - 1));
            end
            for (int k = 0; k < 16; k++)
            begin
                if (span() == 0)
                begin
                    break;
                end
                p = $urandom_range(0, span() - 1);
                if (page_taken[p])
                begin
                    return 12'(p);
                end
            end
            return fallback;
        endfunction

        function void note_request(input bpfa_req_t req);
            int unsigned act;
            int unsigned p;
            int unsigned taken;
            bpfa_rsp_t   rsp;
            act = span();
            p   = req.target_page;
            rsp = '0;
            case (req.opcode)
                OP_REQUEST:
                begin
                    while (search_pos < act && page_taken[search_pos])
                    begin
                        search_pos++;
                    end
                    if (search_pos < act)
                    begin
                        page_taken[search_pos] = 1'b1;
                        if (used_cnt < CNT_MAX)
                        begin
                            used_cnt++;
                        end
                        rsp.ok           = 1'b1;
                        rsp.granted_page = 12'(search_pos);
                    end
                end
                OP_FREE, OP_UNRESERVE:
                begin
                    if (p < act && page_taken[p])
                    begin
                        page_taken[p] = 1'b0;
                        if (req.opcode == OP_FREE && used_cnt > 0)
                        begin
                            used_cnt--;
                        end
                        if (req.opcode == OP_UNRESERVE && resv_cnt > 0)
                        begin
                            resv_cnt--;
                        end
                        if (search_pos > p)
                        begin
                            search_pos = p;
                        end
                        rsp.ok = 1'b1;
                    end
                end
                OP_LOCK, OP_RESERVE:
                begin
                    if (p < act && !page_taken[p])
                    begin
                        page_taken[p] = 1'b1;
                        if (req.opcode == OP_LOCK && used_cnt < CNT_MAX)
                        begin
                            used_cnt++;
                        end
                        if (req.opcode == OP_RESERVE && resv_cnt < CNT_MAX)
                        begin
                            resv_cnt++;
                        end
                        rsp.ok = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            taken              = used_cnt + resv_cnt;
            rsp.free_pages     = (act > taken) ? 13'(act - taken) : 13'd0;
            rsp.used_pages     = 13'(used_cnt);
            rsp.reserved_pages = 13'(resv_cnt);
            expected_q.push_back(rsp);
        endfunction

        function void check_response(input bpfa_rsp_t got);
            bpfa_rsp_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: response with no request pending: %p", $time, got);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.ok !== want.ok || got.granted_page !== want.granted_page
                || got.free_pages !== want.free_pages
                || got.used_pages !== want.used_pages
                || got.reserved_pages !== want.reserved_pages)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: mismatch ok %0d/%0d page %0d/%0d free %0d/%0d used %0d/%0d resv %0d/%0d",
                             $time, want.ok, got.ok, want.granted_page, got.granted_page,
                             want.free_pages, got.free_pages, want.used_pages, got.used_pages,
                             want.reserved_pages, got.reserved_pages);
                end
            end
        endfunction

    endclass

endpackage

@@ sim/bitmap_page_frame_allocator_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bitmap_page_frame_allocator_tb
// Drives directed and random allocator requests under several active page
// counts, with random gaps and receiver stalls, and checks every response.
// ============================================================================
module bitmap_page_frame_allocator_tb;

    import bpfa_pkg::*;
    import bpfa_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned SETTLE      = 8;
    localparam logic [2:0]  OP_UNDEF_LO = 3'd5;
    localparam logic [2:0]  OP_UNDEF_HI = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    bpfa_req_t   in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    bpfa_rsp_t   out_data;
    logic        cfg_we    = 1'b0;
    logic [12:0] cfg_wdata = '0;

    int unsigned cycle_count = 0;
    int unsigned gap_max     = 10;
    bit          long_hold   = 1'b0;

    page_alloc_scoreboard sb = new();

    always #1 clk = ~clk;

    bitmap_page_frame_allocator #(
        .NUM_PAGES (4096)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : receiver
        int unsigned pause;
        wait (rst_n === 1'b1);
        forever
        begin
            pause     = long_hold ? LONG_HOLD : $urandom_range(0, gap_max);
            long_hold = 1'b0;
            if (pause > 0)
            begin
                out_stall <= 1'b1;
                repeat (pause) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            sb.check_response(out_data);
        end
    end

    task automatic send_request(input logic [2:0] op, input logic [11:0] page);
        int unsigned gap;
        bpfa_req_t   req;
        gap             = $urandom_range(0, gap_max);
        req.opcode      = op;
        req.target_page = page;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(req);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_active(input logic [12:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_active(value);
    endtask

    task automatic random_burst(input int unsigned count);
        int unsigned roll;
        int unsigned act;
        logic [2:0]  op;
        logic [11:0] page;
        repeat (count)
        begin
            act  = sb.span();
            roll = $urandom_range(0, 99);
            if (roll < 35)
                op = OP_REQUEST;
            else if (roll < 55)
                op = OP_FREE;
            else if (roll < 67)
                op = OP_LOCK;
            else if (roll < 79)
                op = OP_RESERVE;
            else if (roll < 92)
                op = OP_UNRESERVE;
            else
                op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
            if (act > 0 && $urandom_range(0, 9) < 8)
                page = 12'($urandom_range(0, act - 1));
            else
                page = 12'($urandom);
            if ((op == OP_FREE || op == OP_UNRESERVE) && $urandom_range(0, 1) == 1)
                page = sb.pick_taken(page);
            send_request(op, page);
        end
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_request(OP_REQUEST, 12'd0);
        send_request(OP_REQUEST, 12'hFFF);
        send_request(OP_REQUEST, 12'd0);
        send_request(OP_LOCK, 12'hFFF);
        send_request(OP_LOCK, 12'hFFF);
        send_request(OP_RESERVE, 12'd100);
        send_request(OP_RESERVE, 12'd100);
        send_request(OP_UNRESERVE, 12'd100);
        send_request(OP_UNRESERVE, 12'd100);
        send_request(OP_FREE, 12'd1);
        send_request(OP_REQUEST, 12'd0);
        send_request(OP_RESERVE, 12'd3);
        send_request(OP_REQUEST, 12'd0);
        send_request(OP_FREE, 12'd3);
        send_request(OP_UNRESERVE, 12'hFFF);
        send_request(OP_UNRESERVE, 12'd2);
        send_request(OP_FREE, 12'd0);
        send_request(OP_FREE, 12'd0);
        send_request(OP_UNDEF_LO, 12'd0);
        send_request(3'(OP_UNDEF_LO + 3'd1), 12'hAAA);
        send_request(OP_UNDEF_HI, 12'h555);
        send_request(OP_REQUEST, 12'd0);

        write_active(13'd0);
        send_request(OP_REQUEST, 12'd0);
        send_request(OP_LOCK, 12'd0);
        send_request(OP_FREE, 12'd0);
        random_burst(20);

        write_active(13'd1);
        random_burst(30);

        write_active(13'd16);
        long_hold = 1'b1;
        random_burst(120);

        write_active(13'h1FFF);
        gap_max = 0;
        random_burst(80);
        gap_max = 10;

        write_active(13'd40);
        random_burst(150);

        write_active(13'd4096);
        random_burst(150);

        write_active(13'd100);
        gap_max = 0;
        random_burst(100);
        gap_max = 10;

        drain();
        if (sb.mismatches == 0 && sb.outstanding() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
